// ----- hdl/ppi4_pkg.sv -----
// ----------------------------------------------------------------------------
// ppi4_pkg
// Shared constants, types and the coefficient table of the 4x polyphase
// true-peak interpolator.
// ----------------------------------------------------------------------------
package ppi4_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int TAPS_PER_PHASE = 12;
    localparam int PHASE_COUNT    = 4;
    localparam int COEF_FRAC_BITS = 13;
    localparam int COEF_BITS      = 14;
    localparam int TAP_W          = $clog2(TAPS_PER_PHASE);
    localparam int PHASE_W        = $clog2(PHASE_COUNT);
    localparam int PROD_W         = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W          = PROD_W + TAP_W;

    localparam logic [TAP_W-1:0]   LAST_TAP   = TAP_W'(TAPS_PER_PHASE - 1);
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASE_COUNT - 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    localparam coef_t COEF_TABLE [PHASE_COUNT][TAPS_PER_PHASE] = '{
        '{  14,    90,  -161,   272,  -487,  1125,  7964,  -838,   390,  -218,   122,   -68 },
        '{ -239,   240,  -424,   730, -1364,  3810,  6388, -1641,   832,  -477,   271,  -155 },
        '{ -155,   271,  -477,   832, -1641,  6388,  3810, -1364,   730,  -424,   240,  -239 },
        '{  -68,   122,  -218,   390,  -838,  7964,  1125,  -487,   272,  -161,    90,    14 }
    };

    typedef struct packed {
        logic               shift_en;
        logic               mul_en;
        logic               mul_first;
        logic [TAP_W-1:0]   tap;
        logic [PHASE_W-1:0] phase;
        logic               emit;
        logic               last;
    } ppi4_ctl_t;

endpackage

// ----- hdl/ppi4_delay.sv -----
// ----------------------------------------------------------------------------
// ppi4_delay
// Twelve-entry circular sample delay line with a tap read port addressed
// relative to the newest sample.
// ----------------------------------------------------------------------------
module ppi4_delay
    import ppi4_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  sample_t          in_sample,
    input  logic [TAP_W-1:0] tap,
    output sample_t          tap_sample
);

    sample_t          line_reg [TAPS_PER_PHASE];
    logic [TAP_W-1:0] newest_reg;
    logic [TAP_W-1:0] newest_next;
    logic [TAP_W-1:0] slot;

    assign newest_next = (newest_reg == LAST_TAP) ? '0 : newest_reg + TAP_W'(1);

    always_comb
    begin
        if (newest_reg >= tap)
        begin
            slot = newest_reg - tap;
        end
        else
        begin
            slot = TAP_W'(TAP_W'(TAPS_PER_PHASE) + newest_reg - tap);
        end
    end

    assign tap_sample = line_reg[slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= LAST_TAP;
            for (int i = 0; i < TAPS_PER_PHASE; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            newest_reg            <= newest_next;
            line_reg[newest_next] <= in_sample;
        end
    end

endmodule

// ----- hdl/ppi4_mac.sv -----
// ----------------------------------------------------------------------------
// ppi4_mac
// Shared multiply-accumulate unit with registered product, followed by
// round-to-nearest and saturation of the accumulated sum.
// ----------------------------------------------------------------------------
module ppi4_mac
    import ppi4_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    mul_en,
    input  logic    mul_first,
    input  sample_t sample,
    input  coef_t   coef,
    output sample_t result
);

    localparam int Q_W = ACC_W - COEF_FRAC_BITS;
    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [Q_W-1:0]    quot;

    assign prod_next = sample * coef;

    always_comb
    begin
        acc_next = acc_reg;
        if (prod_valid_reg)
        begin
            acc_next = (prod_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_first_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= mul_en;
            prod_first_reg <= mul_first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // floor((acc + half) / 2^13), then clamp
    assign rounded = acc_reg + HALF;
    assign quot    = rounded[ACC_W-1:COEF_FRAC_BITS];

    always_comb
    begin
        if (quot > SAT_MAX)
        begin
            result = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (quot < SAT_MIN)
        begin
            result = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = quot[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ----- hdl/ppi4_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppi4_ctrl
// Sequencer stepping the shared MAC through twelve taps for each of the
// four phases of one input word.
// ----------------------------------------------------------------------------
module ppi4_ctrl
    import ppi4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    output logic      in_stall,
    output ppi4_ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } ppi4_state_t;

    ppi4_state_t        state_reg;
    ppi4_state_t        state_next;
    logic [TAP_W-1:0]   tap_reg;
    logic [TAP_W-1:0]   tap_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        phase_next    = phase_reg;
        ctl.shift_en  = 1'b0;
        ctl.mul_en    = 1'b0;
        ctl.mul_first = (tap_reg == '0);
        ctl.tap       = tap_reg;
        ctl.phase     = phase_reg;
        ctl.emit      = 1'b0;
        ctl.last      = (phase_reg == LAST_PHASE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.shift_en = 1'b1;
                    tap_next     = '0;
                    phase_next   = '0;
                    state_next   = S_MAC;
                end
            end
            S_MAC:
            begin
                ctl.mul_en = 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + TAP_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ctl.emit = 1'b1;
                    tap_next = '0;
                    if (phase_reg == LAST_PHASE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_reg + PHASE_W'(1);
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- hdl/polyphase_4x_audio_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// polyphase_4x_audio_interpolator_top
// 4x polyphase true-peak interpolator, one audio channel.
//
// Input channel (in_valid / in_stall / in_sample): one signed 24-bit word per
// base-rate sample. The word is shifted into a 12-entry delay line.
// Output channel (out_valid / out_stall / out_sample, phase_index,
// last_of_run): four words per input word, phases 0 to 3 in order, with
// last_of_run set on phase 3. Each is a 12-tap dot product rounded to
// nearest and saturated to 24 bits.
// A single multiply-accumulate unit does all 48 products: each phase does
// twelve multiplies, then an accumulate step and an output step. The first
// result appears once the first phase is through, and no new input word is
// taken until all four phases are done.
// in_stall is high from acceptance until the phase 3 word is loaded into
// the output register. When the receiver stalls, the output register holds
// its word and the sequencer waits at the end of the next phase.
// Reset clears the delay line to zero and empties the output register.
// ----------------------------------------------------------------------------
module polyphase_4x_audio_interpolator_top
    import ppi4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic [PHASE_W-1:0]     phase_index,
    output logic                   last_of_run
);

    ppi4_ctl_t          ctl;
    logic               out_free;
    sample_t            tap_sample;
    sample_t            mac_result;
    logic               out_valid_reg;
    sample_t            out_sample_reg;
    logic [PHASE_W-1:0] phase_index_reg;
    logic               last_of_run_reg;

    assign out_free = !out_valid_reg || !out_stall;

    ppi4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    ppi4_delay u_delay (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (ctl.shift_en),
        .in_sample  (in_sample),
        .tap        (ctl.tap),
        .tap_sample (tap_sample)
    );

    ppi4_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .mul_en    (ctl.mul_en),
        .mul_first (ctl.mul_first),
        .sample    (tap_sample),
        .coef      (COEF_TABLE[ctl.phase][ctl.tap]),
        .result    (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_sample_reg  <= mac_result;
            phase_index_reg <= ctl.phase;
            last_of_run_reg <= ctl.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign phase_index = phase_index_reg;
    assign last_of_run = last_of_run_reg;

endmodule
